// ----- design/deq_pkg.sv -----
package deq_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int WORD_W = 32;
   localparam int OCC_W = 5;

   localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
   localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
   localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
   localparam logic [1:0] CMD_POP_BACK   = 2'd3;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // what one cell does this cycle
   typedef struct packed {
      logic load;
      logic from_left;
      logic from_right;
   } cell_op_type;

   typedef struct packed {
      logic             shift_right;
      logic             shift_left;
      logic             push_back;
      logic             pop_front;
      logic             pop_back;
      logic [1:0]       status;
      logic [CNT_W-1:0] count;
      logic [CNT_W-1:0] count_in;
   } ctrl_type;

endpackage

// ----- design/deq_cell.sv -----
module deq_cell (
   input  logic                                clock,
   input  deq_pkg::cell_op_type                cell_op,
   input  logic signed [deq_pkg::WORD_W-1:0]   push_value,
   input  logic signed [deq_pkg::WORD_W-1:0]   left_word,
   input  logic signed [deq_pkg::WORD_W-1:0]   right_word,
   output logic signed [deq_pkg::WORD_W-1:0]   word_out
);

   logic signed [deq_pkg::WORD_W-1:0] word_ff;
   logic signed [deq_pkg::WORD_W-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (cell_op.load) begin
         word_in = push_value;
      end else if (cell_op.from_left) begin
         word_in = left_word;
      end else if (cell_op.from_right) begin
         word_in = right_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;

endmodule

// ----- design/deq_ctrl.sv -----
module deq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [1:0]           command,
   output deq_pkg::ctrl_type    ctrl
);

   logic [deq_pkg::CNT_W-1:0] count_ff;
   logic [deq_pkg::CNT_W-1:0] count_in;
   logic                      is_push;
   logic                      is_full;
   logic                      is_empty;

   always_comb begin
      is_push  = command inside {deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK};
      is_full  = (count_ff >= deq_pkg::CNT_W'(deq_pkg::DEPTH));
      is_empty = (count_ff == '0);
      count_in = count_ff;

      ctrl             = '0;
      ctrl.status      = deq_pkg::ST_DONE;
      ctrl.count       = count_ff;

      if (is_push) begin
         if (is_full) begin
            ctrl.status = deq_pkg::ST_FULL;
         end else begin
            ctrl.shift_right = accept && (command == deq_pkg::CMD_PUSH_FRONT);
            ctrl.push_back   = accept && (command == deq_pkg::CMD_PUSH_BACK);
            if (accept) begin
               count_in = count_ff + deq_pkg::CNT_W'(1);
            end
         end
      end else begin
         if (is_empty) begin
            ctrl.status = deq_pkg::ST_EMPTY;
         end else begin
            ctrl.pop_front  = accept && (command == deq_pkg::CMD_POP_FRONT);
            ctrl.shift_left = ctrl.pop_front;
            ctrl.pop_back   = accept && (command == deq_pkg::CMD_POP_BACK);
            if (accept) begin
               count_in = count_ff - deq_pkg::CNT_W'(1);
            end
         end
      end
      ctrl.count_in = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- design/double_ended_queue.sv -----
// Double-ended queue of signed 32-bit words, up to DEPTH (16) held.
// Input channel req_*: one command word per item (push front, push back,
// pop front, pop back) with req_push_value used by pushes only.
// Result channel rsp_*: exactly one word per command, carrying the popped
// word (zero unless a pop succeeded), a status (done, pop on empty,
// push on full) and the occupancy after the command.
// Entries live in a row of cells; a push at the front shifts the row one
// cell towards the back, a pop at the front shifts it towards the front,
// a push at the back writes the cell at the current occupancy, a pop at
// the back reads the one below; the front of the queue is always cell 0.
// The result is valid in the cycle after acceptance; while req_stall is
// low, one command is taken every cycle: one row shift is all the work.
// The result sits in an output register; while the receiver stalls with
// a result pending, req_stall is high, and a new command is taken in the
// same cycle the pending result is taken.
// Synchronous reset empties the queue and drops any pending result;
// stored words are not cleared.
module double_ended_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_command,
   input  logic signed [deq_pkg::WORD_W-1:0]   req_push_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [deq_pkg::WORD_W-1:0]   rsp_popped_value,
   output logic [1:0]                          rsp_status,
   output logic [deq_pkg::OCC_W-1:0]           rsp_occupancy
);

   logic                              accept;
   deq_pkg::ctrl_type                 ctrl;
   deq_pkg::cell_op_type              cell_op [deq_pkg::DEPTH];
   logic signed [deq_pkg::WORD_W-1:0] cell_word [deq_pkg::DEPTH];
   logic [deq_pkg::CNT_W-1:0]         last_pos;
   logic signed [deq_pkg::WORD_W-1:0] popped;

   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic signed [deq_pkg::WORD_W-1:0] rsp_popped_value_ff;
   logic signed [deq_pkg::WORD_W-1:0] rsp_popped_value_in;
   logic [1:0]                        rsp_status_ff;
   logic [1:0]                        rsp_status_in;
   logic [deq_pkg::OCC_W-1:0]         rsp_occupancy_ff;
   logic [deq_pkg::OCC_W-1:0]         rsp_occupancy_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   deq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .command (req_command),
      .ctrl    (ctrl)
   );

   for (genvar i = 0; i < deq_pkg::DEPTH; i++) begin : g_cell
      logic signed [deq_pkg::WORD_W-1:0] left_word;
      logic signed [deq_pkg::WORD_W-1:0] right_word;

      always_comb begin
         cell_op[i].load = ctrl.push_back &&
                           (ctrl.count == deq_pkg::CNT_W'(i));
         cell_op[i].from_left  = ctrl.shift_right;
         cell_op[i].from_right = ctrl.shift_left;
      end

      // cell 0 takes the pushed word when the row shifts towards the back
      if (i == 0) begin : g_first
         assign left_word = req_push_value;
      end else begin : g_mid
         assign left_word = cell_word[i-1];
      end
      if (i == deq_pkg::DEPTH - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_inner
         assign right_word = cell_word[i+1];
      end

      deq_cell u_cell (
         .clock      (clock),
         .cell_op    (cell_op[i]),
         .push_value (req_push_value),
         .left_word  (left_word),
         .right_word (right_word),
         .word_out   (cell_word[i])
      );
   end

   assign last_pos = ctrl.count - deq_pkg::CNT_W'(1);

   always_comb begin
      popped = '0;
      if (ctrl.pop_front) begin
         popped = cell_word[0];
      end else if (ctrl.pop_back) begin
         popped = cell_word[last_pos[deq_pkg::IDX_W-1:0]];
      end
   end

   always_comb begin
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      rsp_popped_value_in = rsp_popped_value_ff;
      rsp_status_in       = rsp_status_ff;
      rsp_occupancy_in    = rsp_occupancy_ff;
      if (accept) begin
         rsp_valid_in        = 1'b1;
         rsp_popped_value_in = popped;
         rsp_status_in       = ctrl.status;
         rsp_occupancy_in    = deq_pkg::OCC_W'(ctrl.count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_popped_value_ff <= rsp_popped_value_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_occupancy_ff    <= rsp_occupancy_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_popped_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_occupancy    = rsp_occupancy_ff;

`ifndef SYNTHESIS
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted word produced no result");

   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_occupancy <= deq_pkg::OCC_W'(deq_pkg::DEPTH))
      else $error("occupancy beyond depth");

   a_full_refusal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == deq_pkg::ST_FULL) |->
         (rsp_occupancy == deq_pkg::OCC_W'(deq_pkg::DEPTH) && rsp_popped_value == '0))
      else $error("push refused while not full");

   a_empty_refusal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == deq_pkg::ST_EMPTY) |->
         (rsp_occupancy == '0 && rsp_popped_value == '0))
      else $error("pop refused while not empty");
`endif

endmodule
